// ----- sv/bca_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the block chain allocator.
package bca_pkg;

  localparam int OFF_W     = 16;  // word offset width
  localparam int TDATA_W   = 24;  // both channels: 18 payload bits padded to whole bytes
  localparam int FREE_W    = 32;  // blocks per word of the free map
  localparam int FREE_SH   = 5;   // log2 of FREE_W
  localparam int LINK_FREE = 0;
  localparam int LINK_END  = 1;
  localparam int LINK_BIAS = 2;   // a link to block k is stored as k + LINK_BIAS

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_ADV   = 2'd2,
    CMD_EXT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BROKEN = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_CHK,
    S_LINK,
    S_FREE,
    S_SCAN,
    S_ALLOC,
    S_LINKW,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    FM_NONE,
    FM_INIT,
    FM_SCAN,
    FM_TAKE,
    FM_RELEASE
  } fm_op_t;

endpackage

// ----- sv/bca_link_mem.sv -----
`timescale 1ns / 1ps
// Link table memory: one write and one registered read per cycle, write-first on a collision.
module bca_link_mem #(
  parameter int DEPTH = 256,
  parameter int DW    = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_r;
  logic [DW-1:0] fwd_data_r;
  logic          fwd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r       <= mem[raddr];
    fwd_r      <= we && (waddr == raddr);
    fwd_data_r <= wdata;
  end

  // A read of the entry written in the same cycle returns the new value.
  assign rdata = fwd_r ? fwd_data_r : rd_r;

endmodule

// ----- sv/bca_free_map.sv -----
`timescale 1ns / 1ps
// Free block map: a word memory of free bits with a per-word summary and lowest-free search.
module bca_free_map #(
  parameter int BLOCKS = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bca_pkg::fm_op_t           op,
  input  logic [$clog2(BLOCKS)-1:0] idx,
  output logic                      any_free,
  output logic [$clog2(BLOCKS)-1:0] blk
);

  localparam int NW = (BLOCKS + bca_pkg::FREE_W - 1) / bca_pkg::FREE_W;
  localparam int WW = (NW > 1) ? $clog2(NW) : 1;
  localparam int BW = $clog2(BLOCKS);
  localparam int XW = WW + bca_pkg::FREE_SH;

  logic [bca_pkg::FREE_W-1:0]  mem [NW];
  logic [NW-1:0]               sum_r;
  logic [bca_pkg::FREE_W-1:0]  word_r;
  logic [WW-1:0]               wsel_r;
  logic [WW-1:0]               low_w;
  logic [bca_pkg::FREE_SH-1:0] low_b;
  logic [XW-1:0]               idx_x;
  logic [XW-1:0]               blk_x;
  logic [WW-1:0]               iw;
  logic [bca_pkg::FREE_SH-1:0] ib;
  logic                        we;
  logic [WW-1:0]               wa;
  logic [bca_pkg::FREE_W-1:0]  wmask;
  logic [bca_pkg::FREE_W-1:0]  wdata;

  assign any_free = |sum_r;
  assign idx_x    = XW'(idx);
  assign iw       = idx_x[XW-1:bca_pkg::FREE_SH];
  assign ib       = idx_x[bca_pkg::FREE_SH-1:0];
  assign blk_x    = {wsel_r, low_b};
  assign blk      = blk_x[BW-1:0];

  // Lowest word that still holds a free block.
  always_comb begin
    low_w = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (sum_r[i]) begin
        low_w = WW'(i);
      end
    end
  end

  // Lowest free bit of the word that was read.
  always_comb begin
    low_b = '0;
    for (int i = bca_pkg::FREE_W - 1; i >= 0; i--) begin
      if (word_r[i]) begin
        low_b = bca_pkg::FREE_SH'(i);
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    wa    = iw;
    wmask = '0;
    wdata = '0;
    unique case (op)
      bca_pkg::FM_INIT: begin
        // Bits past the last block stay clear so they are never handed out.
        we = (32'(idx) < NW);
        wa = idx_x[WW-1:0];
        wmask = '1;
        for (int i = 0; i < bca_pkg::FREE_W; i++) begin
          wdata[i] = (32'(idx) * bca_pkg::FREE_W + i) < BLOCKS;
        end
      end
      bca_pkg::FM_TAKE: begin
        we = 1'b1;
        wa = wsel_r;
        wmask[low_b] = 1'b1;
      end
      bca_pkg::FM_RELEASE: begin
        we = 1'b1;
        wa = iw;
        wmask[ib] = 1'b1;
        wdata = '1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < bca_pkg::FREE_W; i++) begin
        if (wmask[i]) begin
          mem[wa][i] <= wdata[i];
        end
      end
    end
    if (op == bca_pkg::FM_SCAN) begin
      word_r <= mem[low_w];
      wsel_r <= low_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '1;
    end else if (op == bca_pkg::FM_TAKE) begin
      sum_r[wsel_r] <= |(word_r & ~wmask);
    end else if (op == bca_pkg::FM_RELEASE) begin
      sum_r[iw] <= 1'b1;
    end
  end

endmodule

// ----- sv/block_chain_allocator.sv -----
`timescale 1ns / 1ps
// Block chain allocator: top level with the command sequencer and result register.
//
// Chained block allocator in the manner of a file allocation table. Each command beat
// gives one result beat. After reset a clearing pass clears the link table and marks
// every block free in the free map; no command beat is taken until it ends. The time
// from an accepted command beat to the next one depends on its path: an offset outside
// the store, or an advance or extend inside a block, is answered after the decode; a
// crossing of a block boundary waits for the link table's registered read (one entry
// per step); allocate, and an extend that appends a block, read the free map before the
// lowest free bit is picked, and the extend then writes two link entries; free chain
// visits one link entry per step. The decode turns a word offset into a block and a
// position with two multiplies. A finished result may wait in the output register
// while the next command is taken.
module block_chain_allocator #(
  parameter int BLOCKS      = 256,
  parameter int BLOCK_WORDS = 128,
  parameter int BASE_WORDS  = 1000
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [bca_pkg::TDATA_W-1:0] in_tdata,   // [1:0] command, [17:2] word_offset
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bca_pkg::TDATA_W-1:0] out_tdata   // [15:0] result_offset, [17:16] status
);

  localparam int BW    = $clog2(BLOCKS);
  localparam int LW    = $clog2(BLOCKS + 2);
  localparam int OW    = bca_pkg::OFF_W;
  localparam int DSH   = OW + $clog2(BLOCK_WORDS);
  localparam longint unsigned RECIP = ((64'd1 << DSH) + BLOCK_WORDS - 1) / BLOCK_WORDS;
  localparam int RW    = OW + 2;
  localparam int PW    = DSH + OW;

  bca_pkg::state_t  state_r, state_nxt;
  bca_pkg::cmd_t    cmd_r;
  logic [OW-1:0]    off_r;
  logic [OW-1:0]    x_r;
  logic             below_r;
  logic [OW-1:0]    q_r;
  logic [BW-1:0]    cur_r;
  logic [BW-1:0]    f_r;
  logic [BW-1:0]    clr_r;
  logic [OW-1:0]    res_r;
  bca_pkg::status_t st_r;
  logic             out_tvalid_r;
  logic [OW-1:0]    out_res_r;
  bca_pkg::status_t out_st_r;

  logic             in_acc;
  logic             out_free;
  logic [OW:0]      x_c;
  logic [PW-1:0]    prod;
  logic             in_range;
  logic             pos_last;
  logic [BW-1:0]    b_c;
  logic [LW-1:0]    e;
  logic [LW-1:0]    nb_l;
  logic             nb_ok;
  logic [BW-1:0]    ofs_blk;
  logic [31:0]      ofs_sum;

  logic             link_we;
  logic [BW-1:0]    link_waddr;
  logic [LW-1:0]    link_wdata;
  logic [BW-1:0]    link_raddr;
  bca_pkg::fm_op_t  fm_op;
  logic [BW-1:0]    fm_idx;
  logic             fm_any;
  logic [BW-1:0]    fm_blk;
  logic             res_load;
  logic [OW-1:0]    res_val;
  bca_pkg::status_t st_val;
  logic             cur_load;
  logic [BW-1:0]    cur_val;

  bca_link_mem #(
    .DEPTH (BLOCKS),
    .DW    (LW)
  ) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (e)
  );

  bca_free_map #(
    .BLOCKS (BLOCKS)
  ) u_free (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (fm_op),
    .idx      (fm_idx),
    .any_free (fm_any),
    .blk      (fm_blk)
  );

  assign in_tready  = (state_r == bca_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(bca_pkg::TDATA_W - OW - 2){1'b0}}, out_st_r, out_res_r};

  // Block index by multiplying with a rounded-up reciprocal; exact for all 16-bit offsets.
  assign x_c  = {1'b0, off_r} - (OW + 1)'(BASE_WORDS);
  assign prod = PW'(x_c[OW-1:0]) * PW'(RW'(RECIP));

  assign in_range = !below_r && ({1'b0, q_r} < (OW + 1)'(BLOCKS));
  assign pos_last = 32'(x_r) == 32'(q_r) * 32'(BLOCK_WORDS) + 32'(BLOCK_WORDS - 1);
  assign b_c      = q_r[BW-1:0];

  assign nb_l  = e - LW'(bca_pkg::LINK_BIAS);
  assign nb_ok = nb_l < LW'(BLOCKS);

  assign ofs_blk = (state_r == bca_pkg::S_ALLOC) ? fm_blk : nb_l[BW-1:0];
  assign ofs_sum = 32'(BASE_WORDS) + 32'(ofs_blk) * 32'(BLOCK_WORDS);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bca_pkg::S_CLEAR: begin
        if (clr_r == BW'(BLOCKS - 1)) begin
          state_nxt = bca_pkg::S_IDLE;
        end
      end
      bca_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = (bca_pkg::cmd_t'(in_tdata[1:0]) == bca_pkg::CMD_ALLOC) ?
                      bca_pkg::S_SCAN : bca_pkg::S_DEC;
        end
      end
      bca_pkg::S_DEC: begin
        state_nxt = bca_pkg::S_CHK;
      end
      bca_pkg::S_CHK: begin
        priority if (!in_range) begin
          state_nxt = bca_pkg::S_OUT;
        end else if (cmd_r == bca_pkg::CMD_FREE) begin
          state_nxt = bca_pkg::S_FREE;
        end else if (!pos_last) begin
          state_nxt = bca_pkg::S_OUT;
        end else begin
          state_nxt = bca_pkg::S_LINK;
        end
      end
      bca_pkg::S_LINK: begin
        if (e == LW'(bca_pkg::LINK_END) && cmd_r == bca_pkg::CMD_EXT) begin
          state_nxt = bca_pkg::S_SCAN;
        end else begin
          state_nxt = bca_pkg::S_OUT;
        end
      end
      bca_pkg::S_FREE: begin
        if (e == LW'(bca_pkg::LINK_FREE) || e == LW'(bca_pkg::LINK_END) || !nb_ok) begin
          state_nxt = bca_pkg::S_OUT;
        end
      end
      bca_pkg::S_SCAN: begin
        state_nxt = fm_any ? bca_pkg::S_ALLOC : bca_pkg::S_OUT;
      end
      bca_pkg::S_ALLOC: begin
        state_nxt = (cmd_r == bca_pkg::CMD_EXT) ? bca_pkg::S_LINKW : bca_pkg::S_OUT;
      end
      bca_pkg::S_LINKW: begin
        state_nxt = bca_pkg::S_OUT;
      end
      bca_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = bca_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bca_pkg::S_IDLE;
      end
    endcase
  end

  // Memory controls and result values.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur_r;
    link_wdata = LW'(bca_pkg::LINK_FREE);
    link_raddr = cur_r;
    fm_op      = bca_pkg::FM_NONE;
    fm_idx     = cur_r;
    res_load   = 1'b0;
    res_val    = '0;
    st_val     = bca_pkg::ST_OK;
    cur_load   = 1'b0;
    cur_val    = b_c;
    unique case (state_r)
      bca_pkg::S_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_r;
        fm_op      = bca_pkg::FM_INIT;
        fm_idx     = clr_r;
      end
      bca_pkg::S_CHK: begin
        link_raddr = b_c;
        priority if (!in_range) begin
          res_load = 1'b1;
          st_val   = bca_pkg::ST_BROKEN;
        end else if (cmd_r == bca_pkg::CMD_FREE) begin
          cur_load = 1'b1;
        end else if (!pos_last) begin
          res_load = 1'b1;
          res_val  = off_r + OW'(1);
        end else begin
          cur_load = 1'b1;
        end
      end
      bca_pkg::S_LINK: begin
        res_load = 1'b1;
        priority if (e == LW'(bca_pkg::LINK_FREE)) begin
          st_val = bca_pkg::ST_BROKEN;
        end else if (e == LW'(bca_pkg::LINK_END)) begin
          // Extend goes on to the allocation, which sets the result again.
          st_val = bca_pkg::ST_BROKEN;
        end else if (!nb_ok) begin
          st_val = bca_pkg::ST_BROKEN;
        end else begin
          res_val = ofs_sum[OW-1:0];
        end
      end
      bca_pkg::S_FREE: begin
        priority if (e == LW'(bca_pkg::LINK_FREE)) begin
          res_load = 1'b1;
          st_val   = bca_pkg::ST_BROKEN;
        end else begin
          link_we    = 1'b1;
          link_waddr = cur_r;
          fm_op      = bca_pkg::FM_RELEASE;
          fm_idx     = cur_r;
          if (e == LW'(bca_pkg::LINK_END)) begin
            res_load = 1'b1;
          end else if (!nb_ok) begin
            res_load = 1'b1;
            st_val   = bca_pkg::ST_BROKEN;
          end else begin
            // The next read may hit the entry cleared now; the memory forwards it.
            link_raddr = nb_l[BW-1:0];
            cur_load   = 1'b1;
            cur_val    = nb_l[BW-1:0];
          end
        end
      end
      bca_pkg::S_SCAN: begin
        if (fm_any) begin
          fm_op = bca_pkg::FM_SCAN;
        end else begin
          res_load = 1'b1;
          st_val   = bca_pkg::ST_FULL;
        end
      end
      bca_pkg::S_ALLOC: begin
        fm_op      = bca_pkg::FM_TAKE;
        link_we    = 1'b1;
        link_waddr = fm_blk;
        link_wdata = LW'(bca_pkg::LINK_END);
        res_load   = 1'b1;
        res_val    = ofs_sum[OW-1:0];
      end
      bca_pkg::S_LINKW: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = LW'(f_r) + LW'(bca_pkg::LINK_BIAS);
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bca_pkg::S_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bca_pkg::S_CLEAR) begin
        clr_r <= clr_r + BW'(1);
      end
      if (state_r == bca_pkg::S_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= bca_pkg::cmd_t'(in_tdata[1:0]);
      off_r <= in_tdata[OW+1:2];
    end
    if (state_r == bca_pkg::S_DEC) begin
      x_r     <= x_c[OW-1:0];
      below_r <= x_c[OW];
      q_r     <= prod[DSH +: OW];
    end
    if (cur_load) begin
      cur_r <= cur_val;
    end
    if (state_r == bca_pkg::S_ALLOC) begin
      f_r <= fm_blk;
    end
    if (res_load) begin
      res_r <= res_val;
      st_r  <= st_val;
    end
    if (state_r == bca_pkg::S_OUT && out_free) begin
      out_res_r <= res_r;
      out_st_r  <= st_r;
    end
  end

endmodule

// ----- tb/bca_chain_checker.sv -----
`timescale 1ns / 1ps
// Checker for the block chain allocator: mirrors the link table and checks every result beat.
module bca_chain_checker #(
  parameter int BLOCKS      = 256,
  parameter int BLOCK_WORDS = 128,
  parameter int BASE_WORDS  = 1000
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [bca_pkg::TDATA_W-1:0] in_tdata,    // [1:0] command, [17:2] word_offset
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [bca_pkg::TDATA_W-1:0] out_tdata,   // [15:0] result_offset, [17:16] status
  output int                          fail_count,
  output int                          outstanding
);

  typedef struct packed {
    logic [bca_pkg::OFF_W-1:0] offset;
    bca_pkg::status_t          status;
  } chain_reply_t;

  chain_reply_t reply_q[$];
  int           chain_link[BLOCKS];
  int           fail_cnt = 0;
  int           pend_cnt = 0;

  assign fail_count  = fail_cnt;
  assign outstanding = pend_cnt;

  function automatic int block_index(int off);
    int blk;
    if (off < BASE_WORDS) return BLOCKS;
    blk = (off - BASE_WORDS) / BLOCK_WORDS;
    return (blk < BLOCKS) ? blk : BLOCKS;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < BLOCKS; i++)
      if (chain_link[i] == bca_pkg::LINK_FREE) return i;
    return BLOCKS;
  endfunction

  // Applies one command to the mirrored link table and returns the reply it should give.
  function automatic chain_reply_t step_link_table(bca_pkg::cmd_t cmd,
                                                   logic [bca_pkg::OFF_W-1:0] word_off);
    chain_reply_t r;
    int off, blk, entry, pos, fb;
    r.offset = '0;
    r.status = bca_pkg::ST_OK;
    off = word_off;
    blk = block_index(off);
    if (cmd == bca_pkg::CMD_ALLOC) begin
      fb = lowest_free();
      if (fb >= BLOCKS) begin
        r.status = bca_pkg::ST_FULL;
      end else begin
        chain_link[fb] = bca_pkg::LINK_END;
        r.offset = bca_pkg::OFF_W'(BASE_WORDS + fb * BLOCK_WORDS);
      end
    end else if (blk >= BLOCKS) begin
      r.status = bca_pkg::ST_BROKEN;
    end else if (cmd == bca_pkg::CMD_FREE) begin
      // Cleared entries read as free, so a walk that loops back stops as broken.
      for (int steps = 0; steps <= BLOCKS; steps++) begin
        entry = chain_link[blk];
        if (entry == bca_pkg::LINK_FREE) begin
          r.status = bca_pkg::ST_BROKEN;
          break;
        end
        chain_link[blk] = bca_pkg::LINK_FREE;
        if (entry == bca_pkg::LINK_END) break;
        blk = entry - bca_pkg::LINK_BIAS;
        if (blk >= BLOCKS) begin
          r.status = bca_pkg::ST_BROKEN;
          break;
        end
      end
    end else begin
      pos = (off - BASE_WORDS) % BLOCK_WORDS;
      if (pos != BLOCK_WORDS - 1) begin
        r.offset = bca_pkg::OFF_W'(off + 1);
      end else begin
        entry = chain_link[blk];
        if (entry == bca_pkg::LINK_FREE) begin
          r.status = bca_pkg::ST_BROKEN;
        end else if (entry == bca_pkg::LINK_END) begin
          if (cmd == bca_pkg::CMD_ADV) begin
            r.status = bca_pkg::ST_BROKEN;
          end else begin
            fb = lowest_free();
            if (fb >= BLOCKS) begin
              r.status = bca_pkg::ST_FULL;
            end else begin
              chain_link[fb]  = bca_pkg::LINK_END;
              chain_link[blk] = fb + bca_pkg::LINK_BIAS;
              r.offset = bca_pkg::OFF_W'(BASE_WORDS + fb * BLOCK_WORDS);
            end
          end
        end else if (entry - bca_pkg::LINK_BIAS >= BLOCKS) begin
          r.status = bca_pkg::ST_BROKEN;
        end else begin
          r.offset = bca_pkg::OFF_W'(BASE_WORDS + (entry - bca_pkg::LINK_BIAS) * BLOCK_WORDS);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    chain_reply_t              want;
    logic [bca_pkg::OFF_W-1:0] got_off;
    logic [1:0]                got_st;
    if (!rst_n) begin
      for (int i = 0; i < BLOCKS; i++) chain_link[i] = bca_pkg::LINK_FREE;
      reply_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_off = out_tdata[bca_pkg::OFF_W-1:0];
        got_st  = out_tdata[bca_pkg::OFF_W+1:bca_pkg::OFF_W];
        if (reply_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("%0t: result beat with nothing pending: offset %0d status %0d",
                     $realtime, got_off, got_st);
          fail_cnt++;
        end else begin
          want = reply_q.pop_front();
          if (got_off !== want.offset || got_st !== want.status) begin
            if (fail_cnt < 10)
              $display("%0t: mismatch: expected offset %0d status %0d, got offset %0d status %0d",
                       $realtime, want.offset, want.status, got_off, got_st);
            fail_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready)
        reply_q.push_back(step_link_table(bca_pkg::cmd_t'(in_tdata[1:0]),
                                          in_tdata[bca_pkg::OFF_W+1:2]));
    end
    pend_cnt = reply_q.size();
  end

endmodule

// ----- tb/block_chain_allocator_tb.sv -----
`timescale 1ns / 1ps
// Top of the block chain allocator testbench: clock, reset, command stimulus and verdict.
module block_chain_allocator_tb;

  localparam int BLOCKS       = 256;
  localparam int BLOCK_WORDS  = 128;
  localparam int BASE_WORDS   = 1000;
  localparam int RANDOM_ITEMS = 900;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 1000000;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [bca_pkg::TDATA_W-1:0] in_tdata   = '0;   // [1:0] command, [17:2] word_offset
  logic                        out_tvalid;
  logic                        out_tready = 1'b1;
  logic [bca_pkg::TDATA_W-1:0] out_tdata;         // [15:0] result_offset, [17:16] status

  int          fail_count;
  int          outstanding;
  int          cycle_cnt = 0;
  bit          in_quiet  = 1'b0;
  bit          out_quiet = 1'b0;
  int unsigned rdy_hold  = 0;

  block_chain_allocator #(
    .BLOCKS     (BLOCKS),
    .BLOCK_WORDS(BLOCK_WORDS),
    .BASE_WORDS (BASE_WORDS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  bca_chain_checker #(
    .BLOCKS     (BLOCKS),
    .BLOCK_WORDS(BLOCK_WORDS),
    .BASE_WORDS (BASE_WORDS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Waits run in bursts, with occasional stretches where a side never idles.
  function automatic int unsigned next_gap(inout bit quiet_run);
    if ($urandom_range(0, 39) == 0) quiet_run = !quiet_run;
    return quiet_run ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [bca_pkg::OFF_W-1:0] word_at(int blk, int pos);
    return bca_pkg::OFF_W'(BASE_WORDS + blk * BLOCK_WORDS + pos);
  endfunction

  // Receiver stall: after each result beat, ready drops for a drawn number of cycles.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      rdy_hold = next_gap(out_quiet);
      out_tready <= (rdy_hold == 0);
    end else if (!out_tready) begin
      if (rdy_hold > 0) rdy_hold--;
      out_tready <= (rdy_hold == 0);
    end
  end

  task automatic send_beat(input bca_pkg::cmd_t cmd, input logic [bca_pkg::OFF_W-1:0] off);
    int unsigned gap;
    gap = next_gap(in_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(bca_pkg::TDATA_W - bca_pkg::OFF_W - 2){1'b0}}, off, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int                        pick, blk, pos, claimed;
    int                        t_alloc, t_ext, t_adv, t_free;
    bit                        fill_phase;
    bca_pkg::cmd_t             cmd;
    logic [bca_pkg::OFF_W-1:0] off;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: chain building, boundaries, out-of-store offsets and bad frees.
    send_beat(bca_pkg::CMD_ALLOC, 16'hFFFF);
    send_beat(bca_pkg::CMD_ADV,   word_at(0, 0));
    send_beat(bca_pkg::CMD_ADV,   word_at(0, BLOCK_WORDS - 1));
    send_beat(bca_pkg::CMD_EXT,   word_at(0, BLOCK_WORDS - 1));
    send_beat(bca_pkg::CMD_ADV,   word_at(0, BLOCK_WORDS - 1));
    send_beat(bca_pkg::CMD_EXT,   word_at(0, BLOCK_WORDS - 1));
    send_beat(bca_pkg::CMD_EXT,   word_at(0, 50));
    send_beat(bca_pkg::CMD_ADV,   word_at(200, BLOCK_WORDS - 1));
    send_beat(bca_pkg::CMD_EXT,   word_at(200, BLOCK_WORDS - 1));
    send_beat(bca_pkg::CMD_ADV,   bca_pkg::OFF_W'(BASE_WORDS - 1));
    send_beat(bca_pkg::CMD_FREE,  16'h0000);
    send_beat(bca_pkg::CMD_EXT,   16'hFFFF);
    send_beat(bca_pkg::CMD_ADV,   word_at(BLOCKS, 0));
    send_beat(bca_pkg::CMD_ADV,   word_at(BLOCKS - 1, BLOCK_WORDS - 1));
    send_beat(bca_pkg::CMD_ADV,   word_at(BLOCKS - 1, BLOCK_WORDS - 2));
    send_beat(bca_pkg::CMD_FREE,  word_at(200, 5));
    send_beat(bca_pkg::CMD_ALLOC, 16'h0000);
    send_beat(bca_pkg::CMD_FREE,  word_at(0, 77));
    send_beat(bca_pkg::CMD_FREE,  word_at(1, 0));
    send_beat(bca_pkg::CMD_ALLOC, 16'h5555);
    send_beat(bca_pkg::CMD_ADV,   word_at(0, BLOCK_WORDS - 1));

    // Random: fill phases drive the table to full, the others mix walks and frees.
    claimed = 2;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      fill_phase = (i < 350) || (i >= 600 && i < 700);
      if (fill_phase) begin
        t_alloc = 70; t_ext = 88; t_adv = 95; t_free = 97;
      end else begin
        t_alloc = 20; t_ext = 45; t_adv = 70; t_free = 90;
      end
      pick = $urandom_range(0, 99);
      blk  = $urandom_range(0, claimed);
      if (pick < t_alloc) begin
        cmd = bca_pkg::CMD_ALLOC;
        off = bca_pkg::OFF_W'($urandom);
      end else if (pick < t_ext) begin
        cmd = bca_pkg::CMD_EXT;
        pos = ($urandom_range(0, 4) != 0) ? BLOCK_WORDS - 1 : $urandom_range(0, BLOCK_WORDS - 1);
        off = word_at(blk, pos);
      end else if (pick < t_adv) begin
        cmd = bca_pkg::CMD_ADV;
        pos = $urandom_range(0, 1) ? BLOCK_WORDS - 1 : $urandom_range(0, BLOCK_WORDS - 1);
        off = word_at(blk, pos);
      end else if (pick < t_free) begin
        cmd = bca_pkg::CMD_FREE;
        off = word_at(blk, $urandom_range(0, BLOCK_WORDS - 1));
      end else begin
        cmd = bca_pkg::cmd_t'($urandom_range(0, 3));
        off = bca_pkg::OFF_W'($urandom);
      end
      if ((cmd == bca_pkg::CMD_ALLOC || cmd == bca_pkg::CMD_EXT) && claimed < BLOCKS - 1)
        claimed++;
      send_beat(cmd, off);
    end
    in_tvalid <= 1'b0;

    // The wait below lets the checker count the last accepted beat as pending.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/bca_pkg.sv
sv/bca_link_mem.sv
sv/bca_free_map.sv
sv/block_chain_allocator.sv
tb/bca_chain_checker.sv
tb/block_chain_allocator_tb.sv
